>>> rtl/gdsl_pkg.sv
// Types, constants and helper functions of the grid replanner.
package gdsl_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 32;
	localparam int COST_W    = 16;
	localparam int KEY_W     = COST_W + 8;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int NCELLS    = MAX_ROWS * MAX_COLS;
	localparam int IDX_W     = $clog2(NCELLS);
	localparam int RDIM_W    = $clog2(MAX_ROWS + 1);
	localparam int CDIM_W    = $clog2(MAX_COLS + 1);
	localparam int DIST_W    = $clog2(MAX_ROWS + MAX_COLS);
	localparam int CFG_W     = 6;
	localparam int POP_LIMIT = 16 * NCELLS;
	localparam int POP_W     = $clog2(POP_LIMIT + 1);
	localparam int DCNT_W    = 3;

	localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
	localparam logic [KEY_W-1:0]  KEY_MAX  = {KEY_W{1'b1}};
	localparam logic [DCNT_W-1:0] NDIR     = 3'd4;

	typedef enum logic [1:0] {
		OP_GOAL   = 2'd0,
		OP_MOVE   = 2'd1,
		OP_OBST   = 2'd2,
		OP_REPLAN = 2'd3
	} op_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		logic              q;
		logic [KEY_W-1:0]  k1;
		logic [COST_W-1:0] k2;
		logic [COST_W-1:0] g;
		logic [COST_W-1:0] rhs;
	} cell_t;

	typedef struct packed {
		logic [KEY_W-1:0]  k1;
		logic [COST_W-1:0] k2;
	} key_t;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] idx;
	} nb_t;

	function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] i);
		return ROW_W'(i / MAX_COLS);
	endfunction

	function automatic logic [COL_W-1:0] col_of(input logic [IDX_W-1:0] i);
		return COL_W'(i % MAX_COLS);
	endfunction

	function automatic logic [IDX_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return IDX_W'(IDX_W'(r) * IDX_W'(MAX_COLS)) + IDX_W'(c);
	endfunction

	function automatic logic [DIST_W-1:0] manhattan(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [ROW_W-1:0] ra, rb, dr;
		logic [COL_W-1:0] ca, cb, dc;
		ra = row_of(a);
		rb = row_of(b);
		ca = col_of(a);
		cb = col_of(b);
		dr = (ra > rb) ? ra - rb : rb - ra;
		dc = (ca > cb) ? ca - cb : cb - ca;
		return DIST_W'(dr) + DIST_W'(dc);
	endfunction

	function automatic nb_t neighbour(input logic [IDX_W-1:0] i, input dir_t d,
			input logic [RDIM_W-1:0] rows, input logic [CDIM_W-1:0] cols);
		nb_t              n;
		logic [ROW_W-1:0] r, nr;
		logic [COL_W-1:0] c, nc;
		r  = row_of(i);
		c  = col_of(i);
		nr = r;
		nc = c;
		unique case (d)
			DIR_UP: begin
				n.ok = (r != '0);
				nr   = r - 1'b1;
			end
			DIR_DOWN: begin
				n.ok = ((RDIM_W'(r) + 1'b1) < rows);
				nr   = r + 1'b1;
			end
			DIR_LEFT: begin
				n.ok = (c != '0);
				nc   = c - 1'b1;
			end
			default: begin
				n.ok = ((CDIM_W'(c) + 1'b1) < cols);
				nc   = c + 1'b1;
			end
		endcase
		n.idx = cell_idx(nr, nc);
		return n;
	endfunction

	function automatic logic [COST_W-1:0] inc_cost(input logic [COST_W-1:0] c);
		return (c == COST_INF) ? c : c + 1'b1;
	endfunction

	function automatic key_t calc_key(input logic [COST_W-1:0] g,
			input logic [COST_W-1:0] rhs, input logic [DIST_W-1:0] h,
			input logic [KEY_W-1:0] km);
		key_t             k;
		logic [COST_W-1:0] m;
		logic [KEY_W:0]   s;
		logic [KEY_W-1:0] s1;
		m  = (g < rhs) ? g : rhs;
		s  = (KEY_W+1)'(m) + (KEY_W+1)'(h);
		s1 = (s >= (KEY_W+1)'(KEY_MAX)) ? KEY_MAX : s[KEY_W-1:0];
		k.k1 = (km >= KEY_MAX - s1) ? KEY_MAX : s1 + km;
		k.k2 = m;
		return k;
	endfunction

	function automatic logic key_less(input key_t a, input key_t b);
		return (a.k1 < b.k1) || ((a.k1 == b.k1) && (a.k2 < b.k2));
	endfunction

endpackage

>>> rtl/grid_dstar_lite_replanner_core.sv
// Incremental grid path replanner: sequencer, cell store and shared key unit.
// After reset a clearing pass over every cell runs before the first transaction is taken;
// set goal clears the cell store again, keeping the obstacle map, then writes the goal cell. Move start
// updates start and the key offset without leaving idle. Set obstacle writes a changed obstacle bit and
// updates the cell and its neighbours; replan does, per queue pop, a full sweep of the cell store (one
// read per cycle) plus vertex updates, then computes the result. Result sits in an output register.
module grid_dstar_lite_replanner_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_idx,
	input  logic [gdsl_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic [gdsl_pkg::ROW_W-1:0]     cell_row,
	input  logic [gdsl_pkg::COL_W-1:0]     cell_col,
	input  logic                           blocked,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gdsl_pkg::ROW_W-1:0]     next_row,
	output logic [gdsl_pkg::COL_W-1:0]     next_col,
	output logic [gdsl_pkg::COST_W-1:0]    start_cost,
	output logic                           reachable
);

	typedef enum logic [23:0] {
		S_CLR      = 24'h000001,
		S_GOAL_WR  = 24'h000002,
		S_IDLE     = 24'h000004,
		S_OB_RD    = 24'h000008,
		S_OB_CHK   = 24'h000010,
		S_SCAN_ST  = 24'h000020,
		S_SCAN     = 24'h000040,
		S_SCAN_END = 24'h000080,
		S_ST_RD    = 24'h000100,
		S_ST_CHK   = 24'h000200,
		S_POP      = 24'h000400,
		S_F_NRD    = 24'h000800,
		S_F_NCHK   = 24'h001000,
		S_F_NEXT   = 24'h002000,
		S_UV_ST    = 24'h004000,
		S_UV_NRD   = 24'h008000,
		S_UV_NCHK  = 24'h010000,
		S_UV_CRD   = 24'h020000,
		S_UV_CWR   = 24'h040000,
		S_RES_RD   = 24'h080000,
		S_RES_G    = 24'h100000,
		S_RES_NRD  = 24'h200000,
		S_RES_NCHK = 24'h400000,
		S_OUT      = 24'h800000
	} state_t;

	state_t state_q, uv_ret_q;

	logic [gdsl_pkg::RDIM_W-1:0] rows_q;
	logic [gdsl_pkg::CDIM_W-1:0] cols_q;
	logic [gdsl_pkg::IDX_W-1:0]  start_q, goal_q, cell_q, uv_cell_q, fc_q;
	logic [gdsl_pkg::IDX_W-1:0]  clr_idx_q, scan_idx_q, cmp_idx_q, top_idx_q, res_next_q;
	logic [gdsl_pkg::KEY_W-1:0]  km_q;
	logic                        clr_all_q, blk_q, need_free_q, found_q, cmp_vld_q, reach_q;
	logic [gdsl_pkg::DCNT_W-1:0] ud_q, fd_q;
	logic [gdsl_pkg::COST_W-1:0] best_q, top_g_q, top_rhs_q, res_cost_q;
	gdsl_pkg::key_t              top_key_q;
	logic [gdsl_pkg::POP_W-1:0]  pops_q;

	logic                        out_valid_q, reach_out_q;
	logic [gdsl_pkg::ROW_W-1:0]  next_row_q;
	logic [gdsl_pkg::COL_W-1:0]  next_col_q;
	logic [gdsl_pkg::COST_W-1:0] cost_out_q;

	// cell store and obstacle map
	gdsl_pkg::cell_t cell_mem_q [gdsl_pkg::NCELLS];
	logic            obs_mem_q  [gdsl_pkg::NCELLS];
	gdsl_pkg::cell_t rd_q;
	logic            obs_rd_q;

	logic [gdsl_pkg::IDX_W-1:0] rd_addr, cell_wa;
	logic                       cell_we, obs_we, obs_wd;
	gdsl_pkg::cell_t            cell_wd;

	// shared neighbour and key units
	logic [gdsl_pkg::IDX_W-1:0]  nb_ctr, kc_cell;
	logic [gdsl_pkg::DCNT_W-1:0] nb_cnt;
	gdsl_pkg::nb_t               nb;
	logic [gdsl_pkg::COST_W-1:0] kc_g, kc_rhs, rhs_new, nb_cost;
	gdsl_pkg::key_t              kc;
	logic                        hit;

	logic                        accept, in_ok;
	logic [gdsl_pkg::IDX_W-1:0]  in_cell;
	logic [gdsl_pkg::DIST_W-1:0] move_h;
	logic [gdsl_pkg::CFG_W-1:0]  cfg_v;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_ok   = (gdsl_pkg::RDIM_W'(cell_row) < rows_q) &&
		(gdsl_pkg::CDIM_W'(cell_col) < cols_q);
	assign in_cell = gdsl_pkg::cell_idx(cell_row, cell_col);
	assign move_h  = gdsl_pkg::manhattan(start_q, in_cell);
	assign cfg_v   = (cfg_wdata == '0) ? gdsl_pkg::CFG_W'(1) : cfg_wdata;

	always_comb begin
		unique case (state_q)
			S_UV_NRD, S_UV_NCHK: begin
				nb_ctr = uv_cell_q;
				nb_cnt = ud_q;
			end
			S_F_NRD, S_F_NCHK: begin
				nb_ctr = fc_q;
				nb_cnt = fd_q;
			end
			default: begin
				nb_ctr = start_q;
				nb_cnt = ud_q;
			end
		endcase
		nb = gdsl_pkg::neighbour(nb_ctr, gdsl_pkg::dir_t'(nb_cnt[1:0]), rows_q, cols_q);
	end

	assign rhs_new = (uv_cell_q == goal_q) ? rd_q.rhs : best_q;
	assign nb_cost = gdsl_pkg::inc_cost(rd_q.g);

	always_comb begin
		unique case (state_q)
			S_GOAL_WR: begin
				kc_cell = goal_q;
				kc_g    = gdsl_pkg::COST_INF;
				kc_rhs  = '0;
			end
			S_ST_CHK: begin
				kc_cell = start_q;
				kc_g    = rd_q.g;
				kc_rhs  = rd_q.rhs;
			end
			S_POP: begin
				kc_cell = top_idx_q;
				kc_g    = top_g_q;
				kc_rhs  = top_rhs_q;
			end
			default: begin
				kc_cell = uv_cell_q;
				kc_g    = rd_q.g;
				kc_rhs  = rhs_new;
			end
		endcase
		kc = gdsl_pkg::calc_key(kc_g, kc_rhs, gdsl_pkg::manhattan(start_q, kc_cell), km_q);
	end

	// queue head sweep: strict less keeps the lowest index on ties
	assign hit = cmp_vld_q && rd_q.q &&
		(!found_q || gdsl_pkg::key_less(gdsl_pkg::key_t'({rd_q.k1, rd_q.k2}), top_key_q));

	always_comb begin
		unique case (state_q)
			S_SCAN:                     rd_addr = scan_idx_q;
			S_ST_RD, S_RES_RD:          rd_addr = start_q;
			S_UV_CRD:                   rd_addr = uv_cell_q;
			S_OB_RD:                    rd_addr = cell_q;
			default:                    rd_addr = nb.idx;
		endcase
	end

	always_comb begin
		cell_we = 1'b0;
		cell_wa = uv_cell_q;
		cell_wd = rd_q;
		obs_we  = 1'b0;
		obs_wd  = blk_q;
		unique case (state_q)
			S_CLR: begin
				cell_we = 1'b1;
				cell_wa = clr_idx_q;
				cell_wd = '{q: 1'b0, k1: '0, k2: '0,
					g: gdsl_pkg::COST_INF, rhs: gdsl_pkg::COST_INF};
				obs_we  = clr_all_q;
				obs_wd  = 1'b0;
			end
			S_GOAL_WR: begin
				cell_we = 1'b1;
				cell_wa = goal_q;
				cell_wd = '{q: 1'b1, k1: kc.k1, k2: kc.k2,
					g: gdsl_pkg::COST_INF, rhs: '0};
			end
			S_OB_CHK: obs_we = (obs_rd_q != blk_q);
			S_POP: begin
				cell_we = 1'b1;
				cell_wa = top_idx_q;
				if (gdsl_pkg::key_less(top_key_q, kc)) begin
					cell_wd = '{q: 1'b1, k1: kc.k1, k2: kc.k2, g: top_g_q, rhs: top_rhs_q};
				end else if (top_g_q > top_rhs_q) begin
					cell_wd = '{q: 1'b0, k1: top_key_q.k1, k2: top_key_q.k2,
						g: top_rhs_q, rhs: top_rhs_q};
				end else begin
					cell_wd = '{q: 1'b0, k1: top_key_q.k1, k2: top_key_q.k2,
						g: gdsl_pkg::COST_INF, rhs: top_rhs_q};
				end
			end
			S_UV_CWR: begin
				cell_we = 1'b1;
				if (rd_q.g != rhs_new) begin
					cell_wd = '{q: 1'b1, k1: kc.k1, k2: kc.k2, g: rd_q.g, rhs: rhs_new};
				end else begin
					cell_wd = '{q: 1'b0, k1: rd_q.k1, k2: rd_q.k2, g: rd_q.g, rhs: rhs_new};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem_q[cell_wa] <= cell_wd;
		end
		rd_q <= cell_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (obs_we) begin
			obs_mem_q[obs_we && state_q == S_CLR ? clr_idx_q : cell_q] <= obs_wd;
		end
		obs_rd_q <= obs_mem_q[rd_addr];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gdsl_pkg::RDIM_W'(gdsl_pkg::MAX_ROWS);
			cols_q <= gdsl_pkg::CDIM_W'(gdsl_pkg::MAX_COLS);
		end else if (cfg_we) begin
			unique case (gdsl_pkg::cfg_reg_t'(cfg_idx))
				gdsl_pkg::REG_ROWS:
					rows_q <= (cfg_v > gdsl_pkg::MAX_ROWS) ?
						gdsl_pkg::RDIM_W'(gdsl_pkg::MAX_ROWS) : gdsl_pkg::RDIM_W'(cfg_v);
				default:
					cols_q <= (cfg_v > gdsl_pkg::MAX_COLS) ?
						gdsl_pkg::CDIM_W'(gdsl_pkg::MAX_COLS) : gdsl_pkg::CDIM_W'(cfg_v);
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			uv_ret_q    <= S_IDLE;
			clr_all_q   <= 1'b1;
			clr_idx_q   <= '0;
			start_q     <= '0;
			goal_q      <= '0;
			km_q        <= '0;
			cell_q      <= '0;
			blk_q       <= 1'b0;
			uv_cell_q   <= '0;
			fc_q        <= '0;
			need_free_q <= 1'b0;
			ud_q        <= '0;
			fd_q        <= '0;
			best_q      <= gdsl_pkg::COST_INF;
			scan_idx_q  <= '0;
			cmp_idx_q   <= '0;
			cmp_vld_q   <= 1'b0;
			found_q     <= 1'b0;
			top_idx_q   <= '0;
			top_key_q   <= '0;
			top_g_q     <= '0;
			top_rhs_q   <= '0;
			pops_q      <= '0;
			res_cost_q  <= '0;
			res_next_q  <= '0;
			reach_q     <= 1'b0;
			out_valid_q <= 1'b0;
			next_row_q  <= '0;
			next_col_q  <= '0;
			cost_out_q  <= '0;
			reach_out_q <= 1'b0;
		end else begin
			// in S_OUT the result load below decides out_valid_q
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == gdsl_pkg::IDX_W'(gdsl_pkg::NCELLS - 1)) begin
						state_q <= clr_all_q ? S_IDLE : S_GOAL_WR;
					end
				end
				S_GOAL_WR: state_q <= S_IDLE;
				S_IDLE: begin
					if (accept) begin
						cell_q <= in_cell;
						blk_q  <= blocked;
						unique case (gdsl_pkg::op_t'(op))
							gdsl_pkg::OP_GOAL: begin
								if (in_ok) begin
									goal_q    <= in_cell;
									km_q      <= '0;
									clr_all_q <= 1'b0;
									clr_idx_q <= '0;
									state_q   <= S_CLR;
								end
							end
							gdsl_pkg::OP_MOVE: begin
								if (in_ok) begin
									km_q <= (km_q >= gdsl_pkg::KEY_MAX - gdsl_pkg::KEY_W'(move_h)) ?
										gdsl_pkg::KEY_MAX : km_q + gdsl_pkg::KEY_W'(move_h);
									start_q <= in_cell;
								end
							end
							gdsl_pkg::OP_OBST: begin
								if (in_ok) begin
									state_q <= S_OB_RD;
								end
							end
							default: begin
								pops_q  <= '0;
								state_q <= S_SCAN_ST;
							end
						endcase
					end
				end
				S_OB_RD: state_q <= S_OB_CHK;
				S_OB_CHK: begin
					if (obs_rd_q != blk_q) begin
						uv_cell_q   <= cell_q;
						uv_ret_q    <= S_F_NRD;
						fc_q        <= cell_q;
						fd_q        <= '0;
						need_free_q <= 1'b0;
						state_q     <= S_UV_ST;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN_ST: begin
					scan_idx_q <= '0;
					cmp_vld_q  <= 1'b0;
					found_q    <= 1'b0;
					state_q    <= (pops_q >= gdsl_pkg::POP_W'(gdsl_pkg::POP_LIMIT)) ?
						S_RES_RD : S_SCAN;
				end
				S_SCAN, S_SCAN_END: begin
					if (hit) begin
						found_q   <= 1'b1;
						top_idx_q <= cmp_idx_q;
						top_key_q <= '{k1: rd_q.k1, k2: rd_q.k2};
						top_g_q   <= rd_q.g;
						top_rhs_q <= rd_q.rhs;
					end
					if (state_q == S_SCAN) begin
						cmp_vld_q  <= 1'b1;
						cmp_idx_q  <= scan_idx_q;
						scan_idx_q <= scan_idx_q + 1'b1;
						if (scan_idx_q == gdsl_pkg::IDX_W'(gdsl_pkg::NCELLS - 1)) begin
							state_q <= S_SCAN_END;
						end
					end else begin
						cmp_vld_q <= 1'b0;
						state_q   <= (found_q || hit) ? S_ST_RD : S_RES_RD;
					end
				end
				S_ST_RD: state_q <= S_ST_CHK;
				S_ST_CHK: begin
					if (!gdsl_pkg::key_less(top_key_q, kc) && rd_q.rhs == rd_q.g) begin
						state_q <= S_RES_RD;
					end else begin
						pops_q  <= pops_q + 1'b1;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					fc_q        <= top_idx_q;
					fd_q        <= '0;
					need_free_q <= 1'b1;
					uv_cell_q   <= top_idx_q;
					uv_ret_q    <= S_F_NRD;
					if (gdsl_pkg::key_less(top_key_q, kc)) begin
						state_q <= S_SCAN_ST;
					end else if (top_g_q > top_rhs_q) begin
						state_q <= S_F_NRD;
					end else begin
						state_q <= S_UV_ST;
					end
				end
				// neighbour walk around fc_q; in repair only free neighbours are updated
				S_F_NRD: begin
					if (fd_q == gdsl_pkg::NDIR) begin
						state_q <= need_free_q ? S_SCAN_ST : S_IDLE;
					end else if (!nb.ok) begin
						fd_q <= fd_q + 1'b1;
					end else if (need_free_q) begin
						state_q <= S_F_NCHK;
					end else begin
						uv_cell_q <= nb.idx;
						uv_ret_q  <= S_F_NEXT;
						state_q   <= S_UV_ST;
					end
				end
				S_F_NCHK: begin
					if (!obs_rd_q) begin
						uv_cell_q <= nb.idx;
						uv_ret_q  <= S_F_NEXT;
						state_q   <= S_UV_ST;
					end else begin
						fd_q    <= fd_q + 1'b1;
						state_q <= S_F_NRD;
					end
				end
				S_F_NEXT: begin
					fd_q    <= fd_q + 1'b1;
					state_q <= S_F_NRD;
				end
				S_UV_ST: begin
					ud_q    <= '0;
					best_q  <= gdsl_pkg::COST_INF;
					state_q <= (uv_cell_q == goal_q) ? S_UV_CRD : S_UV_NRD;
				end
				S_UV_NRD: begin
					if (ud_q == gdsl_pkg::NDIR) begin
						state_q <= S_UV_CRD;
					end else if (!nb.ok) begin
						ud_q <= ud_q + 1'b1;
					end else begin
						state_q <= S_UV_NCHK;
					end
				end
				S_UV_NCHK: begin
					if (!obs_rd_q && nb_cost < best_q) begin
						best_q <= nb_cost;
					end
					ud_q    <= ud_q + 1'b1;
					state_q <= S_UV_NRD;
				end
				S_UV_CRD: state_q <= S_UV_CWR;
				S_UV_CWR: state_q <= uv_ret_q;
				S_RES_RD: state_q <= S_RES_G;
				S_RES_G: begin
					res_cost_q <= rd_q.g;
					res_next_q <= start_q;
					reach_q    <= 1'b0;
					best_q     <= gdsl_pkg::COST_INF;
					ud_q       <= '0;
					state_q    <= S_RES_NRD;
				end
				S_RES_NRD: begin
					if (ud_q == gdsl_pkg::NDIR) begin
						state_q <= S_OUT;
					end else if (!nb.ok) begin
						ud_q <= ud_q + 1'b1;
					end else begin
						state_q <= S_RES_NCHK;
					end
				end
				S_RES_NCHK: begin
					if (!obs_rd_q && nb_cost < best_q) begin
						best_q     <= nb_cost;
						res_next_q <= nb.idx;
						reach_q    <= 1'b1;
					end
					ud_q    <= ud_q + 1'b1;
					state_q <= S_RES_NRD;
				end
				default: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						next_row_q  <= gdsl_pkg::row_of(res_next_q);
						next_col_q  <= gdsl_pkg::col_of(res_next_q);
						cost_out_q  <= res_cost_q;
						reach_out_q <= reach_q;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign next_row   = next_row_q;
	assign next_col   = next_col_q;
	assign start_cost = cost_out_q;
	assign reachable  = reach_out_q;

endmodule
